// ===== src/ssw_pkg.sv =====
// shared types and constants for the sensor sample window averager
package ssw_pkg;

   // fixed field widths
   localparam int SEQ_W    = 32;
   localparam int RAW_W    = 32;
   localparam int SAMPLE_W = 16;
   localparam int MV_W     = 23;
   localparam int FILL_W   = 4;
   localparam int COUNT_W  = 32;
   localparam int TOTAL_W  = 64;

   // valid reading range and millivolt scale
   localparam logic signed [RAW_W-1:0] RAW_MIN  = -32'sd32768;
   localparam logic signed [RAW_W-1:0] RAW_MAX  = 32'sd32767;
   localparam logic signed [MV_W-1:0]  MV_SCALE = 23'sd100;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // quotient bits produced per divider cycle
   localparam int DIV_RADIX = 8;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_SEQ   = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef struct packed {
      status_type              status;
      logic signed [MV_W-1:0]  mv;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== src/ssw_front.sv =====
// front end: sequence check, range check and millivolt scaling
module ssw_front import ssw_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [SEQ_W-1:0]        req_sample_seq,
   input  logic signed [RAW_W-1:0] req_raw_counts,
   input  queue_status_type        q_status,
   output logic                    push,
   output entry_type               push_entry
);

   logic [SEQ_W-1:0]       expected_ff;
   logic [SEQ_W-1:0]       expected_in;
   logic signed [MV_W-1:0] raw_ext;
   logic                   in_range;

   // accept whenever the queue has room
   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full;

   // scale the low half of the reading to millivolts
   assign raw_ext  = {{(MV_W-SAMPLE_W){req_raw_counts[SAMPLE_W-1]}},
                      req_raw_counts[SAMPLE_W-1:0]};
   assign in_range = (req_raw_counts >= RAW_MIN) && (req_raw_counts <= RAW_MAX);

   // classify, sequence check first
   always_comb begin
      push_entry.mv = raw_ext * MV_SCALE;
      priority if (req_sample_seq != expected_ff) begin
         push_entry.status = ST_SEQ;
      end else if (!in_range) begin
         push_entry.status = ST_RANGE;
      end else begin
         push_entry.status = ST_OK;
      end
   end

   // expected number advances on every accepted word
   assign expected_in = push ? expected_ff + 32'd1 : expected_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff <= '0;
      end else begin
         expected_ff <= expected_in;
      end
   end

endmodule

// ===== src/ssw_queue.sv =====
// short queue of classified words between front and back
module ssw_queue import ssw_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  entry_type        push_entry,
   input  logic             pop,
   output entry_type        head,
   output queue_status_type q_status
);

   localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
   localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(QUEUE_DEPTH);

   entry_type         entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign q_status.full  = (count_ff == CNT_FULL);
   assign q_status.empty = (count_ff == '0);
   assign head           = entry_ff[rd_ptr_ff];

   // pointer and fill tracking
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== src/ssw_back.sv =====
// back end: window update, average divide, batch and totals, result register
module ssw_back import ssw_pkg::*; #(
   parameter int WINDOW_DEPTH = 8,
   parameter int BATCH_SIZE   = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  queue_status_type          q_status,
   input  entry_type                 head,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output status_type                rsp_status,
   output logic signed [MV_W-1:0]    rsp_average_mv,
   output logic [FILL_W-1:0]         rsp_window_fill,
   output logic                      rsp_batch_end,
   output logic [COUNT_W-1:0]        rsp_batch_total,
   output logic signed [TOTAL_W-1:0] rsp_average_sum,
   output logic [COUNT_W-1:0]        rsp_range_error_total,
   output logic [COUNT_W-1:0]        rsp_seq_error_total
);

   localparam int CNT_W    = $clog2(WINDOW_DEPTH + 1);
   localparam int SLOT_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int SUM_W    = MV_W + $clog2(WINDOW_DEPTH);
   localparam int DIV_ITER = (SUM_W + DIV_RADIX - 1) / DIV_RADIX;
   localparam int DIV_W    = DIV_ITER * DIV_RADIX;
   localparam int REM_W    = CNT_W + 1;
   localparam int ITER_W   = (DIV_ITER > 1) ? $clog2(DIV_ITER) : 1;
   localparam int BF_W     = (BATCH_SIZE > 1) ? $clog2(BATCH_SIZE) : 1;

   localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(WINDOW_DEPTH);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_DEPTH - 1);
   localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(DIV_ITER - 1);
   localparam logic [BF_W-1:0]   BF_LAST   = BF_W'(BATCH_SIZE - 1);

   typedef enum logic [5:0] {
      BK_IDLE = 6'b000001,
      BK_SUM  = 6'b000010,
      BK_PREP = 6'b000100,
      BK_DIV  = 6'b001000,
      BK_SIGN = 6'b010000,
      BK_FIN  = 6'b100000
   } back_state_type;

   back_state_type state_ff, state_in;

   // window memory
   logic signed [MV_W-1:0]    window_mem [WINDOW_DEPTH];
   logic signed [MV_W-1:0]    rd_ff;

   // item in flight
   status_type                status_ff, status_in;
   logic signed [MV_W-1:0]    mv_ff, mv_in;
   logic                      full_ff, full_in;

   // window bookkeeping
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [SLOT_W-1:0]         slot_ff, slot_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic signed [SUM_W-1:0]   old_term;
   logic signed [SUM_W-1:0]   mag_s;

   // divider
   logic                      neg_ff, neg_in;
   logic [DIV_W-1:0]          dq_ff, dq_in, dq_t;
   logic [REM_W-1:0]          rem_ff, rem_in, rem_t;
   logic [ITER_W-1:0]         iter_ff, iter_in;
   logic signed [MV_W-1:0]    avg_ff, avg_in;
   logic [MV_W-1:0]           quot;

   // running state
   logic signed [MV_W-1:0]    last_avg_ff, last_avg_in;
   logic [BF_W-1:0]           bfill_ff, bfill_in;
   logic [COUNT_W-1:0]        batch_ff, batch_in;
   logic [TOTAL_W-1:0]        total_ff, total_in;
   logic [COUNT_W-1:0]        range_err_ff, range_err_in;
   logic [COUNT_W-1:0]        seq_err_ff, seq_err_in;
   logic                      bend;

   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      load_rsp;
   logic                      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = (state_ff == BK_IDLE) && !q_status.empty;
   assign load_rsp = (state_ff == BK_FIN) && out_free;

   // one divider cycle: DIV_RADIX restoring steps
   always_comb begin
      rem_t = rem_ff;
      dq_t  = dq_ff;
      for (int k = 0; k < DIV_RADIX; k++) begin
         rem_t = {rem_t[REM_W-2:0], dq_t[DIV_W-1]};
         dq_t  = {dq_t[DIV_W-2:0], 1'b0};
         if (rem_t >= {1'b0, count_ff}) begin
            rem_t   = rem_t - {1'b0, count_ff};
            dq_t[0] = 1'b1;
         end
      end
   end

   assign old_term = full_ff ? SUM_W'(rd_ff) : '0;
   assign mag_s    = sum_ff[SUM_W-1] ? -sum_ff : sum_ff;
   assign quot     = dq_ff[MV_W-1:0];

   // sequencer and next state
   always_comb begin
      state_in     = state_ff;
      status_in    = status_ff;
      mv_in        = mv_ff;
      full_in      = full_ff;
      count_in     = count_ff;
      slot_in      = slot_ff;
      sum_in       = sum_ff;
      neg_in       = neg_ff;
      dq_in        = dq_ff;
      rem_in       = rem_ff;
      iter_in      = iter_ff;
      avg_in       = avg_ff;
      last_avg_in  = last_avg_ff;
      bfill_in     = bfill_ff;
      batch_in     = batch_ff;
      total_in     = total_ff;
      range_err_in = range_err_ff;
      seq_err_in   = seq_err_ff;
      bend         = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         BK_IDLE: begin
            if (pop) begin
               status_in = head.status;
               mv_in     = head.mv;
               if (head.status == ST_OK) begin
                  full_in  = (count_ff == CNT_FULL);
                  count_in = (count_ff == CNT_FULL) ? count_ff : count_ff + 1'b1;
                  slot_in  = (slot_ff == SLOT_LAST) ? '0 : slot_ff + 1'b1;
                  state_in = BK_SUM;
               end else begin
                  state_in = BK_FIN;
               end
            end
         end
         BK_SUM: begin
            sum_in   = sum_ff + SUM_W'(mv_ff) - old_term;
            state_in = BK_PREP;
         end
         BK_PREP: begin
            neg_in   = sum_ff[SUM_W-1];
            dq_in    = DIV_W'(unsigned'(mag_s));
            rem_in   = '0;
            iter_in  = '0;
            state_in = BK_DIV;
         end
         BK_DIV: begin
            dq_in  = dq_t;
            rem_in = rem_t;
            if (iter_ff == ITER_LAST) begin
               state_in = BK_SIGN;
            end else begin
               iter_in = iter_ff + 1'b1;
            end
         end
         BK_SIGN: begin
            avg_in   = neg_ff ? -signed'(quot) : signed'(quot);
            state_in = BK_FIN;
         end
         BK_FIN: begin
            if (out_free) begin
               unique case (status_ff)
                  ST_OK: begin
                     last_avg_in = avg_ff;
                     total_in    = total_ff + TOTAL_W'(avg_ff);
                     if (bfill_ff == BF_LAST) begin
                        bfill_in = '0;
                        batch_in = batch_ff + 32'd1;
                        bend     = 1'b1;
                     end else begin
                        bfill_in = bfill_ff + 1'b1;
                     end
                  end
                  ST_SEQ: begin
                     seq_err_in = seq_err_ff + 32'd1;
                  end
                  ST_RANGE: begin
                     range_err_in = range_err_ff + 32'd1;
                  end
                  default: begin
                  end
               endcase
               rsp_valid_in = 1'b1;
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // control and running state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         count_ff     <= '0;
         slot_ff      <= '0;
         sum_ff       <= '0;
         last_avg_ff  <= '0;
         bfill_ff     <= '0;
         batch_ff     <= '0;
         total_ff     <= '0;
         range_err_ff <= '0;
         seq_err_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         slot_ff      <= slot_in;
         sum_ff       <= sum_in;
         last_avg_ff  <= last_avg_in;
         bfill_ff     <= bfill_in;
         batch_ff     <= batch_in;
         total_ff     <= total_in;
         range_err_ff <= range_err_in;
         seq_err_ff   <= seq_err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      mv_ff     <= mv_in;
      full_ff   <= full_in;
      neg_ff    <= neg_in;
      dq_ff     <= dq_in;
      rem_ff    <= rem_in;
      iter_ff   <= iter_in;
      avg_ff    <= avg_in;
   end

   // window memory: read the oldest entry and overwrite it in the same cycle
   always_ff @(posedge clock) begin
      if (pop && (head.status == ST_OK)) begin
         rd_ff               <= window_mem[slot_ff];
         window_mem[slot_ff] <= head.mv;
      end
   end

   // result word
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_status            <= status_ff;
         rsp_average_mv        <= last_avg_in;
         rsp_window_fill       <= FILL_W'(count_ff);
         rsp_batch_end         <= bend;
         rsp_batch_total       <= batch_in;
         rsp_average_sum       <= total_in;
         rsp_range_error_total <= range_err_in;
         rsp_seq_error_total   <= seq_err_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== src/sensor_sample_window_average_core.sv =====
// sensor sample window averager: sequence check, moving average, batch totals
//
// Input words (req_) carry a sequence number and a raw reading; each one
// gives exactly one result word (rsp_) in arrival order. Both channels use
// valid/stall: a word moves on a clock edge with valid high and stall low.
// A front stage checks the sequence number, range-checks the reading and
// scales it to millivolts, then places the word in a two-entry queue. The
// back stage updates the window, divides the window sum by the fill count
// with a radix-256 restoring divider, and loads the result register.
// A good reading passes the back stage through its sum, prepare, divide,
// sign and finish steps, with the divide step repeated until all quotient
// bits are done; a rejected reading goes straight to the finish step. The
// back stage takes no new word until it is through with the last one. The
// queue keeps the input open while the back stage works. When the receiver
// stalls, the result word holds, the back stage waits in its last step and
// the queue fills before req_stall rises.
// Synchronous reset clears the counters, totals and window fill; window
// entries are only used after they have been written.
module sensor_sample_window_average_core import ssw_pkg::*; #(
   parameter int WINDOW_DEPTH = 8,
   parameter int BATCH_SIZE   = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [SEQ_W-1:0]          req_sample_seq,
   input  logic signed [RAW_W-1:0]   req_raw_counts,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_status,
   output logic signed [MV_W-1:0]    rsp_average_mv,
   output logic [FILL_W-1:0]         rsp_window_fill,
   output logic                      rsp_batch_end,
   output logic [COUNT_W-1:0]        rsp_batch_total,
   output logic signed [TOTAL_W-1:0] rsp_average_sum,
   output logic [COUNT_W-1:0]        rsp_range_error_total,
   output logic [COUNT_W-1:0]        rsp_seq_error_total
);

   logic             push;
   logic             pop;
   entry_type        push_entry;
   entry_type        head;
   queue_status_type q_status;
   status_type       status_word;

   assign rsp_status = status_word;

   // classify incoming words
   ssw_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_seq (req_sample_seq),
      .req_raw_counts (req_raw_counts),
      .q_status       (q_status),
      .push           (push),
      .push_entry     (push_entry)
   );

   // decoupling queue
   ssw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .q_status   (q_status)
   );

   // window, divider and totals
   ssw_back #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .BATCH_SIZE   (BATCH_SIZE)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .q_status              (q_status),
      .head                  (head),
      .pop                   (pop),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_status            (status_word),
      .rsp_average_mv        (rsp_average_mv),
      .rsp_window_fill       (rsp_window_fill),
      .rsp_batch_end         (rsp_batch_end),
      .rsp_batch_total       (rsp_batch_total),
      .rsp_average_sum       (rsp_average_sum),
      .rsp_range_error_total (rsp_range_error_total),
      .rsp_seq_error_total   (rsp_seq_error_total)
   );

   // queue never reports full and empty together
   a_queue_flags: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue full and empty at once");

   // a rejected reading never closes a batch
   a_error_no_batch: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_OK)) |-> !rsp_batch_end)
      else $error("batch end on a rejected reading");

   // no result word right after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule
